// File: hw/rtl/efd_pkg.sv
package efd_pkg;

  localparam int YEAR_W = 14;
  localparam int JDN_W  = 23;
  localparam int DAY_W  = 5;
  localparam int EMON_W = 3;
  localparam int CMON_W = 2;
  localparam int PMON_W = 3;
  localparam int WDAY_W = 3;

  // Reciprocal constants for division by a constant, quotient = (x * R) >> S.
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam logic [15:0] RECIP_19  = 16'd55189;
  localparam logic [5:0]  RECIP_25  = 6'd41;
  localparam logic [7:0]  RECIP_3   = 8'd171;
  localparam logic [9:0]  RECIP_30  = 10'd547;
  localparam logic [7:0]  RECIP_7S  = 8'd147;
  localparam logic [23:0] RECIP_7W  = 24'd9586981;

  // Day number of March 1st minus 31, without the year and century terms.
  localparam logic [JDN_W-1:0] JDN_OFFSET = 23'd1721125;

  localparam logic [EMON_W-1:0] EMON_MARCH = 3'd3;
  localparam logic [EMON_W-1:0] EMON_APRIL = 3'd4;
  localparam logic [CMON_W-1:0] CMON_FEB   = 2'd2;
  localparam logic [CMON_W-1:0] CMON_MARCH = 2'd3;
  localparam logic [PMON_W-1:0] PMON_MAY   = 3'd5;
  localparam logic [PMON_W-1:0] PMON_JUNE  = 3'd6;

  typedef struct packed {
    logic             valid;
    logic [7:0]       s;
    logic             leap;
    logic [JDN_W-1:0] jbase;
  } efd_easter_t;

endpackage

// File: hw/rtl/easter_feast_dates.sv
// A year accepted with start passes the registers of stages 1 to 9 before its result word shows.
// Throughput: one year per cycle; busy is always low and the pipeline never stalls.
// The result word shows on the out_ ports for one cycle, marked by out_valid.
// Reset (rst_n low, synchronous) clears the valid bits of all stages; words in flight are lost.
module easter_feast_dates
  import efd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [YEAR_W-1:0] in_year,
  output logic              out_valid,
  output logic [JDN_W-1:0]  out_easter_day_number,
  output logic [DAY_W-1:0]  out_easter_day,
  output logic [EMON_W-1:0] out_easter_month,
  output logic [DAY_W-1:0]  out_carnival_day,
  output logic [CMON_W-1:0] out_carnival_month,
  output logic [DAY_W-1:0]  out_corpus_day,
  output logic [PMON_W-1:0] out_corpus_month,
  output logic [WDAY_W-1:0] out_easter_weekday,
  output logic [WDAY_W-1:0] out_carnival_weekday,
  output logic [WDAY_W-1:0] out_corpus_weekday
);

  efd_easter_t easter;

  assign busy = 1'b0;

  efd_computus u_computus (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .year     (in_year),
    .easter_o (easter)
  );

  efd_dates u_dates (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .easter_i              (easter),
    .out_valid             (out_valid),
    .out_easter_day_number (out_easter_day_number),
    .out_easter_day        (out_easter_day),
    .out_easter_month      (out_easter_month),
    .out_carnival_day      (out_carnival_day),
    .out_carnival_month    (out_carnival_month),
    .out_corpus_day        (out_corpus_day),
    .out_corpus_month      (out_corpus_month),
    .out_easter_weekday    (out_easter_weekday),
    .out_carnival_weekday  (out_carnival_weekday),
    .out_corpus_weekday    (out_corpus_weekday)
  );

endmodule

// File: hw/rtl/efd_computus.sv
module efd_computus
  import efd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [YEAR_W-1:0] year,
  output efd_easter_t       easter_o
);

  // Stage 1: century and golden number quotients.
  logic [26:0] prod100;
  logic [29:0] prod19;
  logic        v1_r;
  logic [YEAR_W-1:0] y1_r;
  logic [7:0]  b1_r;
  logic [9:0]  q19_1_r;

  assign prod100 = 27'(year) * 27'(RECIP_100);
  assign prod19  = 30'(year) * 30'(RECIP_19);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start;
    end
    y1_r    <= year;
    b1_r    <= prod100[26:19];
    q19_1_r <= prod19[29:20];
  end

  // Stage 2: remainders, f term, leap flag and year part of the day number.
  logic [YEAR_W-1:0] a14;
  logic [YEAR_W-1:0] c14;
  logic [8:0]  bp8;
  logic [14:0] prodf;
  logic [9:0]  cb;
  logic [11:0] cb3;
  logic [JDN_W-1:0] jb;
  logic        leap;
  logic        v2_r;
  logic [7:0]  b2_r;
  logic [4:0]  a2_r;
  logic [6:0]  c2_r;
  logic [2:0]  f2_r;
  logic [JDN_W-1:0] jb2_r;
  logic        leap2_r;

  assign a14   = y1_r - 14'(q19_1_r) * 14'd19;
  assign c14   = y1_r - 14'(14'(b1_r) * 14'd100);
  assign bp8   = 9'(b1_r) + 9'd8;
  assign prodf = 15'(bp8) * 15'(RECIP_25);
  assign cb    = 10'(b1_r) + 10'd49;
  assign cb3   = 12'(cb) * 12'd3;
  assign jb    = 23'(y1_r) * 23'd365 + 23'(y1_r[13:2]) + JDN_OFFSET - 23'(cb3[11:2]);
  assign leap  = (c14[1:0] == 2'd0) && ((c14[6:0] != 7'd0) || (b1_r[1:0] == 2'd0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    b2_r    <= b1_r;
    a2_r    <= a14[4:0];
    c2_r    <= c14[6:0];
    f2_r    <= prodf[12:10];
    jb2_r   <= jb;
    leap2_r <= leap;
  end

  // Stage 3: g term.
  logic [7:0]  gx;
  logic [15:0] prodg;
  logic        v3_r;
  logic [7:0]  b3_r;
  logic [4:0]  a3_r;
  logic [6:0]  c3_r;
  logic [6:0]  g3_r;
  logic [JDN_W-1:0] jb3_r;
  logic        leap3_r;

  assign gx    = b2_r - 8'(f2_r) + 8'd1;
  assign prodg = 16'(gx) * 16'(RECIP_3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    b3_r    <= b2_r;
    a3_r    <= a2_r;
    c3_r    <= c2_r;
    g3_r    <= prodg[15:9];
    jb3_r   <= jb2_r;
    leap3_r <= leap2_r;
  end

  // Stage 4: epact sum and its quotient by 30.
  logic [9:0]  hx;
  logic [19:0] prod30;
  logic        v4_r;
  logic [9:0]  hx4_r;
  logic [4:0]  q30_4_r;
  logic [1:0]  e4_r;
  logic [4:0]  a4_r;
  logic [6:0]  c4_r;
  logic [JDN_W-1:0] jb4_r;
  logic        leap4_r;

  assign hx = 10'(a3_r) * 10'd19 + 10'(b3_r) - 10'(b3_r[7:2]) - 10'(g3_r) + 10'd15;
  assign prod30 = 20'(hx) * 20'(RECIP_30);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    hx4_r   <= hx;
    q30_4_r <= prod30[18:14];
    e4_r    <= b3_r[1:0];
    a4_r    <= a3_r;
    c4_r    <= c3_r;
    jb4_r   <= jb3_r;
    leap4_r <= leap3_r;
  end

  // Stage 5: epact and weekday sum with its quotient by 7.
  logic [9:0]  h10;
  logic [4:0]  h;
  logic [6:0]  lx;
  logic [13:0] prod7;
  logic        v5_r;
  logic [4:0]  h5_r;
  logic [6:0]  lx5_r;
  logic [3:0]  q7_5_r;
  logic [4:0]  a5_r;
  logic [JDN_W-1:0] jb5_r;
  logic        leap5_r;

  assign h10   = hx4_r - 10'(q30_4_r) * 10'd30;
  assign h     = h10[4:0];
  assign lx    = 7'd32 + 7'({e4_r, 1'b0}) + 7'({c4_r[6:2], 1'b0}) - 7'(h) - 7'(c4_r[1:0]);
  assign prod7 = 14'(lx) * 14'(RECIP_7S);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
    h5_r    <= h;
    lx5_r   <= lx;
    q7_5_r  <= prod7[13:10];
    a5_r    <= a4_r;
    jb5_r   <= jb4_r;
    leap5_r <= leap4_r;
  end

  // Stage 6: correction term and the combined offset s.
  logic [6:0] l7;
  logic [2:0] l;
  logic [8:0] mx;
  logic       m;
  logic [7:0] s;
  logic       v6_r;
  logic [7:0] s6_r;
  logic [JDN_W-1:0] jb6_r;
  logic       leap6_r;

  assign l7 = lx5_r - 7'(q7_5_r) * 7'd7;
  assign l  = l7[2:0];
  assign mx = 9'(a5_r) + 9'(h5_r) * 9'd11 + 9'(l) * 9'd22;
  assign m  = (mx >= 9'd451);
  assign s  = 8'(h5_r) + 8'(l) + 8'd114 - (m ? 8'd7 : 8'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
    s6_r    <= s;
    jb6_r   <= jb5_r;
    leap6_r <= leap5_r;
  end

  assign easter_o.valid = v6_r;
  assign easter_o.s     = s6_r;
  assign easter_o.leap  = leap6_r;
  assign easter_o.jbase = jb6_r;

  a_s_range: assert property (@(posedge clk) disable iff (!rst_n)
    v6_r |-> (s6_r >= 8'd107) && (s6_r <= 8'd149))
    else $error("offset s out of range");

endmodule

// File: hw/rtl/efd_dates.sv
module efd_dates
  import efd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  efd_easter_t       easter_i,
  output logic              out_valid,
  output logic [JDN_W-1:0]  out_easter_day_number,
  output logic [DAY_W-1:0]  out_easter_day,
  output logic [EMON_W-1:0] out_easter_month,
  output logic [DAY_W-1:0]  out_carnival_day,
  output logic [CMON_W-1:0] out_carnival_month,
  output logic [DAY_W-1:0]  out_corpus_day,
  output logic [PMON_W-1:0] out_corpus_month,
  output logic [WDAY_W-1:0] out_easter_weekday,
  output logic [WDAY_W-1:0] out_carnival_weekday,
  output logic [WDAY_W-1:0] out_corpus_weekday
);

  // Stage 7: Easter date, its day number and the two derived dates.
  logic             april;
  logic [7:0]       ed8;
  logic [7:0]       t8;
  logic [5:0]       t;
  logic [JDN_W-1:0] ejd;
  logic [5:0]       cd6;
  logic [5:0]       pd6;
  logic             v7_r;
  logic [JDN_W-1:0] ejd7_r;
  logic [DAY_W-1:0] ed7_r;
  logic [EMON_W-1:0] em7_r;
  logic [DAY_W-1:0] cd7_r;
  logic [CMON_W-1:0] cm7_r;
  logic [DAY_W-1:0] pd7_r;
  logic [PMON_W-1:0] pm7_r;

  assign april = (easter_i.s >= 8'd124);
  assign ed8   = easter_i.s - (april ? 8'd123 : 8'd92);
  assign t8    = easter_i.s - 8'd93;
  assign t     = t8[5:0];
  assign ejd   = easter_i.jbase + (april ? 23'd61 : 23'd30) + 23'(ed8[4:0]);
  assign cd6   = (t >= 6'd47) ? (t - 6'd46) : (t - (easter_i.leap ? 6'd17 : 6'd18));
  assign pd6   = (t < 6'd32) ? t : (t - 6'd31);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= easter_i.valid;
    end
    ejd7_r <= ejd;
    ed7_r  <= ed8[4:0];
    em7_r  <= april ? EMON_APRIL : EMON_MARCH;
    cd7_r  <= cd6[4:0];
    cm7_r  <= (t >= 6'd47) ? CMON_MARCH : CMON_FEB;
    pd7_r  <= pd6[4:0];
    pm7_r  <= (t < 6'd32) ? PMON_MAY : PMON_JUNE;
  end

  // Stage 8: quotient of the day number by 7.
  logic [46:0]      prodw;
  logic             v8_r;
  logic [JDN_W-1:0] ejd8_r;
  logic [20:0]      q8_r;
  logic [DAY_W-1:0] ed8_r;
  logic [EMON_W-1:0] em8_r;
  logic [DAY_W-1:0] cd8_r;
  logic [CMON_W-1:0] cm8_r;
  logic [DAY_W-1:0] pd8_r;
  logic [PMON_W-1:0] pm8_r;

  assign prodw = 47'(ejd7_r) * 47'(RECIP_7W);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else begin
      v8_r <= v7_r;
    end
    ejd8_r <= ejd7_r;
    q8_r   <= prodw[46:26];
    ed8_r  <= ed7_r;
    em8_r  <= em7_r;
    cd8_r  <= cd7_r;
    cm8_r  <= cm7_r;
    pd8_r  <= pd7_r;
    pm8_r  <= pm7_r;
  end

  // Stage 9: weekdays and the output register.
  logic [JDN_W-1:0]  w23;
  logic [WDAY_W-1:0] w;
  logic [WDAY_W-1:0] cw;
  logic [WDAY_W-1:0] pw;
  logic              out_valid_r;
  logic [JDN_W-1:0]  out_ejd_r;
  logic [DAY_W-1:0]  out_ed_r;
  logic [EMON_W-1:0] out_em_r;
  logic [DAY_W-1:0]  out_cd_r;
  logic [CMON_W-1:0] out_cm_r;
  logic [DAY_W-1:0]  out_pd_r;
  logic [PMON_W-1:0] out_pm_r;
  logic [WDAY_W-1:0] out_ew_r;
  logic [WDAY_W-1:0] out_cw_r;
  logic [WDAY_W-1:0] out_pw_r;

  assign w23 = ejd8_r - 23'(q8_r) * 23'd7;
  assign w   = w23[2:0];
  assign cw  = (w >= 3'd5) ? (w - 3'd5) : (w + 3'd2);
  assign pw  = (w >= 3'd3) ? (w - 3'd3) : (w + 3'd4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v8_r;
    end
    out_ejd_r <= ejd8_r;
    out_ed_r  <= ed8_r;
    out_em_r  <= em8_r;
    out_cd_r  <= cd8_r;
    out_cm_r  <= cm8_r;
    out_pd_r  <= pd8_r;
    out_pm_r  <= pm8_r;
    out_ew_r  <= w;
    out_cw_r  <= cw;
    out_pw_r  <= pw;
  end

  assign out_valid             = out_valid_r;
  assign out_easter_day_number = out_ejd_r;
  assign out_easter_day        = out_ed_r;
  assign out_easter_month      = out_em_r;
  assign out_carnival_day      = out_cd_r;
  assign out_carnival_month    = out_cm_r;
  assign out_corpus_day        = out_pd_r;
  assign out_corpus_month      = out_pm_r;
  assign out_easter_weekday    = out_ew_r;
  assign out_carnival_weekday  = out_cw_r;
  assign out_corpus_weekday    = out_pw_r;

  a_easter_month: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_em_r == EMON_MARCH) || (out_em_r == EMON_APRIL))
    else $error("Easter month out of range");

  a_march_day: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_em_r == EMON_MARCH) |-> (out_ed_r >= 5'd22))
    else $error("Easter in March before the 22nd");

  a_corpus_month: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pm_r == PMON_MAY) || (out_pm_r == PMON_JUNE))
    else $error("Corpus Christi month out of range");

endmodule
